// ===== src/ltfs_pkg.sv =====
// Shared constants and types for the lower-triangular forward-substitution core.
// Used by the front, queue, back and top-level modules.
package ltfs_pkg;

    localparam int LTFS_MAX_ROWS   = 16;
    localparam int LTFS_IDX_W      = 4;
    localparam int LTFS_DATA_W     = 32;
    localparam int LTFS_ACC_W      = 64;
    localparam int LTFS_QDEPTH     = 4;
    localparam int LTFS_Q_PTR_W    = 2;
    localparam int LTFS_QCNT_W     = 3;
    localparam int LTFS_DIV_STEPS  = 32;
    localparam int LTFS_DIV_CNT_W  = 5;

    localparam logic [LTFS_DATA_W-1:0] LTFS_Q_MAX = 32'h7FFF_FFFF;
    localparam logic [LTFS_DATA_W-1:0] LTFS_Q_MIN = 32'h8000_0000;

    typedef struct packed {
        logic                          is_diag;
        logic [LTFS_IDX_W-1:0]         row;
        logic [LTFS_IDX_W-1:0]         column;
        logic signed [LTFS_DATA_W-1:0] coefficient;
        logic signed [LTFS_DATA_W-1:0] rhs;
    } t_entry;

    typedef struct packed {
        logic   push;
        t_entry entry;
    } t_push;

endpackage

// ===== src/ltfs_front.sv =====
// Front end: accepts items, drops out-of-range and upper-triangle ones, tags the diagonal.
// Depends on ltfs_pkg; feeds ltfs_queue.
module ltfs_front
    import ltfs_pkg::*;
#(
    parameter int MAX_ROWS = LTFS_MAX_ROWS
) (
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [LTFS_IDX_W-1:0]         i_row,
    input  logic [LTFS_IDX_W-1:0]         i_column,
    input  logic signed [LTFS_DATA_W-1:0] i_coefficient,
    input  logic signed [LTFS_DATA_W-1:0] i_rhs,
    input  logic                          i_q_full,
    output t_push                         o_push
);

    logic in_range;
    logic lower;

    assign in_range = (32'(i_row) < MAX_ROWS) && (32'(i_column) < MAX_ROWS);
    assign lower    = i_column <= i_row;
    assign o_stall  = i_q_full;

    always_comb begin
        o_push.push              = i_valid && !i_q_full && in_range && lower;
        o_push.entry.is_diag     = i_column == i_row;
        o_push.entry.row         = i_row;
        o_push.entry.column      = i_column;
        o_push.entry.coefficient = i_coefficient;
        o_push.entry.rhs         = i_rhs;
    end

endmodule

// ===== src/ltfs_queue.sv =====
// Short FIFO of classified items between the front and back ends.
// Depends on ltfs_pkg.
module ltfs_queue
    import ltfs_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_empty,
    output t_entry o_head
);

    t_entry                  r_mem [0:LTFS_QDEPTH-1];
    logic [LTFS_Q_PTR_W-1:0] r_wr;
    logic [LTFS_Q_PTR_W-1:0] r_rd;
    logic [LTFS_QCNT_W-1:0]  r_count;

    assign o_full  = r_count == LTFS_QCNT_W'(LTFS_QDEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr] <= i_push.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push.push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push.push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== src/ltfs_back.sv =====
// Back end: multiply-accumulate for off-diagonal items, bit-serial division for the diagonal,
// solution store and output register. Depends on ltfs_pkg; fed by ltfs_queue.
module ltfs_back
    import ltfs_pkg::*;
#(
    parameter int MAX_ROWS = LTFS_MAX_ROWS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    input  t_entry                        i_head,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [LTFS_IDX_W-1:0]         o_solved_row,
    output logic signed [LTFS_DATA_W-1:0] o_solution,
    output logic                          o_divide_by_zero,
    output logic                          o_saturated
);

    localparam int STORE_DEPTH = (MAX_ROWS < (1 << LTFS_IDX_W)) ? MAX_ROWS : (1 << LTFS_IDX_W);
    localparam int SIDX_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_ACC  = 7'b0000100,
        S_MAG  = 7'b0001000,
        S_CHK  = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_FIN  = 7'b1000000
    } t_state;

    t_state                        r_state;
    t_state                        n_state;
    logic [LTFS_DATA_W-1:0]        r_store [0:STORE_DEPTH-1];
    logic signed [LTFS_DATA_W-1:0] r_x;
    logic signed [LTFS_DATA_W-1:0] r_coef;
    logic signed [LTFS_ACC_W-1:0]  r_prod;
    logic [LTFS_ACC_W-1:0]         r_sum;
    logic [LTFS_ACC_W-1:0]         r_num;
    logic [LTFS_ACC_W-1:0]         r_nmag;
    logic [LTFS_DATA_W-1:0]        r_dmag;
    logic                          r_nneg;
    logic                          r_dz;
    logic                          r_ovf;
    logic [LTFS_DATA_W-1:0]        r_rem;
    logic [LTFS_DATA_W-1:0]        r_quo;
    logic [LTFS_DIV_CNT_W-1:0]     r_cnt;
    logic [LTFS_IDX_W-1:0]         r_row;
    logic                          r_out_valid;
    logic [LTFS_IDX_W-1:0]         r_out_row;
    logic [LTFS_DATA_W-1:0]        r_out_sol;
    logic                          r_out_dz;
    logic                          r_out_sat;

    logic                   out_free;
    logic                   ovf;
    logic [LTFS_DATA_W-1:0] shifted;
    logic                   ge;
    logic                   neg;
    logic [LTFS_DATA_W-1:0] fin_sol;
    logic                   fin_sat;

    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = (r_state == S_IDLE) && !i_q_empty;
    assign ovf      = r_nmag[LTFS_ACC_W-1:LTFS_DATA_W] >= r_dmag;
    assign shifted  = {r_rem[LTFS_DATA_W-2:0], r_quo[LTFS_DATA_W-1]};
    assign ge       = shifted >= r_dmag;
    assign neg      = r_nneg ^ r_coef[LTFS_DATA_W-1];

    always_comb begin
        fin_sol = r_quo;
        fin_sat = 1'b0;
        if (r_dz) begin
            fin_sol = '0;
        end else if (r_ovf) begin
            fin_sat = 1'b1;
            fin_sol = neg ? LTFS_Q_MIN : LTFS_Q_MAX;
        end else if (neg) begin
            if (r_quo > LTFS_Q_MIN) begin
                fin_sat = 1'b1;
                fin_sol = LTFS_Q_MIN;
            end else begin
                fin_sol = ~r_quo + 1'b1;
            end
        end else if (r_quo > LTFS_Q_MAX) begin
            fin_sat = 1'b1;
            fin_sol = LTFS_Q_MAX;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    if (!i_head.is_diag) begin
                        n_state = S_MUL;
                    end else if (i_head.coefficient == '0) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_MAG;
                    end
                end
            end
            S_MUL:   n_state = S_ACC;
            S_ACC:   n_state = S_IDLE;
            S_MAG:   n_state = S_CHK;
            S_CHK:   n_state = ovf ? S_FIN : S_DIV;
            S_DIV: begin
                if (r_cnt == LTFS_DIV_CNT_W'(LTFS_DIV_STEPS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_ACC) begin
                r_sum <= r_sum + r_prod;
            end
            if ((r_state == S_FIN) && out_free) begin
                r_sum       <= '0;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_x    <= r_store[i_head.column[SIDX_W-1:0]];
                r_coef <= i_head.coefficient;
                r_row  <= i_head.row;
                r_dz   <= i_head.coefficient == '0;
                r_num  <= {i_head.rhs, {LTFS_DATA_W{1'b0}}} - r_sum;
            end
            S_MUL: begin
                r_prod <= r_coef * r_x;
            end
            S_MAG: begin
                r_nneg <= r_num[LTFS_ACC_W-1];
                r_nmag <= r_num[LTFS_ACC_W-1] ? (~r_num + 1'b1) : r_num;
                r_dmag <= r_coef[LTFS_DATA_W-1] ? (~r_coef + 1'b1) : r_coef;
            end
            S_CHK: begin
                r_ovf <= ovf;
                r_rem <= r_nmag[LTFS_ACC_W-1:LTFS_DATA_W];
                r_quo <= r_nmag[LTFS_DATA_W-1:0];
                r_cnt <= '0;
            end
            S_DIV: begin
                r_rem <= ge ? (shifted - r_dmag) : shifted;
                r_quo <= {r_quo[LTFS_DATA_W-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
            end
            S_FIN: begin
                if (out_free) begin
                    r_store[r_row[SIDX_W-1:0]] <= fin_sol;
                    r_out_row <= r_row;
                    r_out_sol <= fin_sol;
                    r_out_dz  <= r_dz;
                    r_out_sat <= fin_sat;
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    assign o_valid          = r_out_valid;
    assign o_solved_row     = r_out_row;
    assign o_solution       = r_out_sol;
    assign o_divide_by_zero = r_out_dz;
    assign o_saturated      = r_out_sat;

endmodule

// ===== src/lower_triangular_forward_solve_core.sv =====
// Top level of the lower-triangular forward-substitution core; coefficients and solutions are signed Q16.16.
// Depends on ltfs_pkg, ltfs_front, ltfs_queue and ltfs_back.
//
// Coefficients enter row by row; each off-diagonal one is multiplied by the stored solution of
// its column and summed, and the diagonal one (carrying the right-hand side) yields one result
// (rhs - sum) / diagonal, saturated to Q16.16, with flags for a zero diagonal and for clamping.
// Out-of-range and upper-triangle items are accepted and dropped. A four-item queue lets input
// run ahead of the execution unit. An off-diagonal item takes store read, multiply, accumulate;
// a diagonal item takes magnitude, overflow check, the radix-2 divider that retires one quotient
// bit a cycle, and finish, skipping the divider on overflow and all but finish for a zero
// diagonal; a result waits in the output register while the next item proceeds.
module lower_triangular_forward_solve_core
    import ltfs_pkg::*;
#(
    parameter int MAX_ROWS = LTFS_MAX_ROWS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [LTFS_IDX_W-1:0]         i_row,
    input  logic [LTFS_IDX_W-1:0]         i_column,
    input  logic signed [LTFS_DATA_W-1:0] i_coefficient,
    input  logic signed [LTFS_DATA_W-1:0] i_rhs,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [LTFS_IDX_W-1:0]         o_solved_row,
    output logic signed [LTFS_DATA_W-1:0] o_solution,
    output logic                          o_divide_by_zero,
    output logic                          o_saturated
);

    t_push  q_push;
    t_entry q_head;
    logic   q_full;
    logic   q_empty;
    logic   q_pop;

    ltfs_front #(
        .MAX_ROWS(MAX_ROWS)
    ) u_front (
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_row         (i_row),
        .i_column      (i_column),
        .i_coefficient (i_coefficient),
        .i_rhs         (i_rhs),
        .i_q_full      (q_full),
        .o_push        (q_push)
    );

    ltfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    ltfs_back #(
        .MAX_ROWS(MAX_ROWS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (q_empty),
        .i_head           (q_head),
        .o_pop            (q_pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_solved_row     (o_solved_row),
        .o_solution       (o_solution),
        .o_divide_by_zero (o_divide_by_zero),
        .o_saturated      (o_saturated)
    );

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    a_dz_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divide_by_zero |-> o_solution == '0 && !o_saturated)
        else $error("zero diagonal gave nonzero or saturated result");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |-> o_solution == LTFS_Q_MAX || o_solution == LTFS_Q_MIN)
        else $error("saturated result not at a range limit");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for lower_triangular_forward_solve_core.
// Depends on ltfs_pkg; predicts each solved unknown and checks the results in order.
module tb;
    import ltfs_pkg::*;

    localparam int HOLD_OFF_CYCLES = 150;
    localparam int TAIL_CYCLES     = 60;

    typedef struct {
        logic [LTFS_IDX_W-1:0]  row;
        logic [LTFS_DATA_W-1:0] value;
        logic                   dz;
        logic                   sat;
    } t_solution;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_valid       = 1'b0;
    logic                          o_stall;
    logic [LTFS_IDX_W-1:0]         i_row         = '0;
    logic [LTFS_IDX_W-1:0]         i_column      = '0;
    logic signed [LTFS_DATA_W-1:0] i_coefficient = '0;
    logic signed [LTFS_DATA_W-1:0] i_rhs         = '0;
    logic                          o_valid;
    logic                          i_stall       = 1'b0;
    logic [LTFS_IDX_W-1:0]         o_solved_row;
    logic signed [LTFS_DATA_W-1:0] o_solution;
    logic                          o_divide_by_zero;
    logic                          o_saturated;

    t_solution              pending_solutions[$];
    logic [LTFS_DATA_W-1:0] x_store [LTFS_MAX_ROWS];
    bit                     x_known [LTFS_MAX_ROWS];
    logic [LTFS_ACC_W-1:0]  acc_q32       = '0;
    int                     mismatch_count = 0;
    int                     items_sent     = 0;
    bit                     tx_idle_en     = 1'b0;
    bit                     rx_idle_en     = 1'b0;
    bit                     hold_request   = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    lower_triangular_forward_solve_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_row           (i_row),
        .i_column        (i_column),
        .i_coefficient   (i_coefficient),
        .i_rhs           (i_rhs),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_solved_row    (o_solved_row),
        .o_solution      (o_solution),
        .o_divide_by_zero(o_divide_by_zero),
        .o_saturated     (o_saturated)
    );

    function automatic t_solution divide_q16(input logic [63:0] num,
                                             input logic signed [31:0] den);
        t_solution         res;
        logic [63:0]       nmag;
        logic [63:0]       dmag;
        logic [63:0]       q;
        logic signed [63:0] dwide;
        res.row   = '0;
        res.dz    = 1'b0;
        res.sat   = 1'b0;
        dwide     = den;
        nmag      = num[63] ? (~num + 64'd1) : num;
        dmag      = den[31] ? -dwide : dwide;
        q         = nmag / dmag;
        if (num[63] ^ den[31]) begin
            if (q > 64'h8000_0000) begin
                res.value = LTFS_Q_MIN;
                res.sat   = 1'b1;
            end else begin
                res.value = 32'(~q + 64'd1);
            end
        end else if (q > 64'h7FFF_FFFF) begin
            res.value = LTFS_Q_MAX;
            res.sat   = 1'b1;
        end else begin
            res.value = q[31:0];
        end
        return res;
    endfunction

    task automatic predict_solution(input logic [3:0] row, input logic [3:0] col,
                                    input logic signed [31:0] coef,
                                    input logic signed [31:0] rhs_v);
        t_solution          res;
        logic signed [63:0] cw;
        logic signed [63:0] xw;
        if (col > row)
            return;
        if (col < row) begin
            cw      = coef;
            xw      = $signed(x_store[col]);
            acc_q32 = acc_q32 + 64'(cw * xw);
            return;
        end
        if (coef == 0) begin
            res.value = '0;
            res.dz    = 1'b1;
            res.sat   = 1'b0;
        end else begin
            res = divide_q16({rhs_v, 32'b0} - acc_q32, coef);
        end
        res.row      = row;
        x_store[row] = res.value;
        x_known[row] = 1'b1;
        acc_q32      = '0;
        pending_solutions.push_back(res);
    endtask

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic send_item(input logic [3:0] row, input logic [3:0] col,
                             input logic [31:0] coef, input logic [31:0] rhs_v);
        int gap;
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_row         <= row;
        i_column      <= col;
        i_coefficient <= coef;
        i_rhs         <= rhs_v;
        do @(posedge i_clk); while (o_stall);
        predict_solution(row, col, coef, rhs_v);
        if (col <= row)
            items_sent++;
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (pending_solutions.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_value();
        logic signed [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 3))
            0:       return v;
            1:       return v >>> $urandom_range(1, 31);
            2:       return v >>> $urandom_range(16, 31);
            default: return v >>> $urandom_range(24, 31);
        endcase
    endfunction

    function automatic logic [31:0] rand_diag();
        logic signed [31:0] v;
        v = $urandom;
        if ($urandom_range(0, 11) == 0)
            return '0;
        if ($urandom_range(0, 3) == 0)
            return rand_value();
        return v >>> $urandom_range(0, 8);
    endfunction

    function automatic logic [31:0] rand_rhs();
        logic signed [31:0] v;
        v = $urandom;
        if ($urandom_range(0, 3) == 0)
            return v;
        return v >>> $urandom_range(8, 31);
    endfunction

    task automatic solve_system(input int n);
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < r; c++) begin
                if (r < LTFS_MAX_ROWS - 1 && $urandom_range(0, 19) == 0)
                    send_item(4'(r), 4'($urandom_range(r + 1, LTFS_MAX_ROWS - 1)),
                              $urandom, $urandom);
                send_item(4'(r), 4'(c), rand_value(), $urandom);
            end
            send_item(4'(r), 4'(r), rand_diag(), rand_rhs());
        end
    endtask

    function automatic int rand_size();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(9, LTFS_MAX_ROWS);
        return $urandom_range(1, 8);
    endfunction

    always @(posedge i_clk) begin
        t_solution want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_solutions.size() == 0) begin
                flag_mismatch($sformatf("unexpected result for row %0d", o_solved_row));
            end else begin
                want = pending_solutions.pop_front();
                if (o_solved_row !== want.row)
                    flag_mismatch($sformatf("solved_row %0d, want %0d",
                                            o_solved_row, want.row));
                if (o_solution !== want.value)
                    flag_mismatch($sformatf("row %0d solution %h, want %h",
                                            want.row, o_solution, want.value));
                if (o_divide_by_zero !== want.dz)
                    flag_mismatch($sformatf("row %0d divide_by_zero %b, want %b",
                                            want.row, o_divide_by_zero, want.dz));
                if (o_saturated !== want.sat)
                    flag_mismatch($sformatf("row %0d saturated %b, want %b",
                                            want.row, o_saturated, want.sat));
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                i_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
                hold_request = 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    task automatic test_directed();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        send_item(4'd0, 4'd0, 32'h0001_0000, 32'h0000_0003);
        send_item(4'd1, 4'd0, 32'h0000_8000, 32'h0000_0000);
        send_item(4'd1, 4'd1, 32'h4000_0000, 32'h0000_0100);
        send_item(4'd2, 4'd2, 32'h0000_0000, 32'h1234_5678);
        send_item(4'd3, 4'd2, 32'h7FFF_FFFF, 32'h0000_0000);
        send_item(4'd3, 4'd3, 32'h0000_0002, 32'hFFFF_FFFF);
        send_item(4'd4, 4'd4, 32'h0000_0001, 32'h7FFF_FFFF);
        send_item(4'd5, 4'd5, 32'h0000_0001, 32'h8000_0000);
        send_item(4'd6, 4'd6, 32'h8000_0000, 32'h8000_0000);
        send_item(4'd7, 4'd7, 32'h7FFF_FFFF, 32'h0000_0000);
        send_item(4'd8, 4'd8, 32'h0000_0003, 32'hFFFF_FFFF);
        send_item(4'd9, 4'd9, 32'hFFFF_FFFF, 32'h0000_0001);
        send_item(4'd2, 4'd9, 32'h0001_0000, 32'h0001_0000);
        send_item(4'd0, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // sum carries across rows until the next diagonal
        send_item(4'd10, 4'd0, 32'h0001_0000, 32'h0000_0000);
        send_item(4'd12, 4'd1, 32'hFFFF_0000, 32'h0000_0000);
        send_item(4'd11, 4'd11, 32'h4000_0000, 32'h0000_0010);
        // four products of 2^62: the sum wraps to zero
        send_item(4'd15, 4'd3, 32'h8000_0000, 32'h0000_0000);
        send_item(4'd15, 4'd5, 32'h8000_0000, 32'h0000_0000);
        send_item(4'd15, 4'd3, 32'h8000_0000, 32'h0000_0000);
        send_item(4'd15, 4'd5, 32'h8000_0000, 32'h0000_0000);
        send_item(4'd15, 4'd15, 32'h0001_0000, 32'h0000_0005);
        send_item(4'd14, 4'd4, 32'h8000_0000, 32'h0000_0000);
        send_item(4'd14, 4'd14, 32'h8000_0000, 32'h7FFF_FFFF);
        wait_for_results();
    endtask

    task automatic test_random_systems();
        while (items_sent < 1100) begin
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            solve_system(rand_size());
        end
    endtask

    task automatic test_back_pressure();
        tx_idle_en   = 1'b0;
        hold_request = 1'b1;
        solve_system(10);
        wait_for_results();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        solve_system(LTFS_MAX_ROWS);
        wait_for_results();
    endtask

    task automatic test_broken_sequences();
        int r;
        int c;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        while (items_sent < 1600) begin
            r = $urandom_range(0, LTFS_MAX_ROWS - 1);
            case ($urandom_range(0, 5))
                0: solve_system($urandom_range(1, 6));
                1: begin
                    if (r < LTFS_MAX_ROWS - 1)
                        send_item(4'(r), 4'($urandom_range(r + 1, LTFS_MAX_ROWS - 1)),
                                  $urandom, $urandom);
                end
                2: send_item(4'(r), 4'(r), 32'h0000_0000, $urandom);
                default: begin
                    c = (r > 0) ? $urandom_range(0, r - 1) : 0;
                    if (r > 0 && x_known[c])
                        send_item(4'(r), 4'(c), rand_value(), $urandom);
                    else
                        send_item(4'(r), 4'(r), rand_diag(), rand_rhs());
                end
            endcase
        end
    endtask

    task automatic test_quiet_tail();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        while (items_sent < 1850)
            solve_system(rand_size());
        wait_for_results();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_systems();
        test_back_pressure();
        test_broken_sequences();
        test_quiet_tail();
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
